/* rtl/core/stes_pkg.sv */
package stes_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TIME_W          = 32;
    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 2;
    localparam int STATUS_W        = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_ADD     = 2'd1,
        FUNC_NEAREST = 2'd2,
        FUNC_QUERY   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        func_t              func;
        logic [TIME_W-1:0]  time_in;
        logic [DATA_W-1:0]  value_in;
    } stes_req_t;

    typedef struct packed {
        status_t            status;
        logic [DATA_W-1:0]  value_out;
        logic [TIME_W-1:0]  duration;
    } stes_res_t;

endpackage

/* rtl/core/stes_ram.sv */
module stes_ram #(
    parameter int DEPTH = stes_pkg::DEPTH_DEF,
    parameter int WIDTH = stes_pkg::TIME_W + stes_pkg::DATA_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/stes_seq.sv */
module stes_seq #(
    parameter int DEPTH       = stes_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = stes_pkg::VALUE_WIDTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1),
    localparam int SW = (VALUE_WIDTH < stes_pkg::DATA_W) ? VALUE_WIDTH : stes_pkg::DATA_W,
    localparam int MW = stes_pkg::TIME_W + SW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  stes_pkg::stes_req_t req,
    output logic                res_valid,
    input  logic                res_ready,
    output stes_pkg::stes_res_t res,
    output logic [CW-1:0]       res_count,
    output logic                wr_en,
    output logic [AW-1:0]       wr_addr,
    output logic [MW-1:0]       wr_data,
    output logic [AW-1:0]       rd_addr,
    input  logic [MW-1:0]       rd_data
);
    import stes_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_ADD_PUT,
        S_FIND,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [TIME_W-1:0] best_reg, best_next;
    logic [SW-1:0]     sel_reg, sel_next;
    status_t           status_reg, status_next;
    logic [TIME_W-1:0] t_reg;
    logic [SW-1:0]     v_reg;

    logic [TIME_W-1:0] rd_time;
    logic [SW-1:0]     rd_val;
    logic [TIME_W-1:0] gap;
    logic              take;
    logic [CW-1:0]     idx_inc;
    logic [CW-1:0]     count_dec;

    assign rd_time   = rd_data[TIME_W-1:0];
    assign rd_val    = rd_data[MW-1:TIME_W];
    assign gap       = (t_reg >= rd_time) ? (t_reg - rd_time) : (rd_time - t_reg);
    // the first entry is taken unconditionally so it wins when nothing is closer
    assign take      = (gap < best_reg) || (idx_reg == '0);
    assign idx_inc   = CW'(idx_reg) + CW'(1);
    assign count_dec = count_reg - CW'(1);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        sel_next    = sel_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_inc[AW-1:0];
        wr_data     = rd_data;
        rd_addr     = idx_reg;
        in_ready    = (state_reg == S_IDLE);
        res_valid   = (state_reg == S_DONE);

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    status_next = ST_OK;
                    sel_next    = '0;
                    best_next   = '1;
                    case (req.func)
                        FUNC_CLEAR: begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        FUNC_ADD: begin
                            if (count_reg == CW'(DEPTH)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else if (count_reg == '0) begin
                                wr_en      = 1'b1;
                                wr_addr    = '0;
                                wr_data    = {req.value_in[SW-1:0], req.time_in};
                                count_next = CW'(1);
                                last_next  = req.time_in;
                                state_next = S_DONE;
                            end else begin
                                // walk down from the last entry, shifting later ones up
                                idx_next   = count_dec[AW-1:0];
                                rd_addr    = count_dec[AW-1:0];
                                state_next = S_ADD;
                            end
                        end
                        FUNC_NEAREST: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                idx_next   = '0;
                                rd_addr    = '0;
                                state_next = S_FIND;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADD: begin
                wr_en = 1'b1;
                if (rd_time >= t_reg) begin
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = S_ADD_PUT;
                    end else begin
                        idx_next = idx_reg - 1'b1;
                        rd_addr  = idx_reg - 1'b1;
                    end
                end else begin
                    wr_data    = {v_reg, t_reg};
                    count_next = count_reg + CW'(1);
                    if (idx_inc == count_reg) begin
                        last_next = t_reg;
                    end
                    state_next = S_DONE;
                end
            end
            S_ADD_PUT: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = {v_reg, t_reg};
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_FIND: begin
                if (take) begin
                    best_next = gap;
                    sel_next  = rd_val;
                end
                if (idx_inc == count_reg) begin
                    state_next = S_DONE;
                end else begin
                    idx_next = idx_inc[AW-1:0];
                    rd_addr  = idx_inc[AW-1:0];
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        sel_reg    <= sel_next;
        status_reg <= status_next;
        if (in_valid && in_ready) begin
            t_reg <= req.time_in;
            v_reg <= req.value_in[SW-1:0];
        end
    end

    assign res.status    = status_reg;
    assign res.value_out = DATA_W'(sel_reg);
    assign res.duration  = (count_reg == '0) ? '0 : last_reg;
    assign res_count     = count_reg;

endmodule

/* rtl/core/sorted_timestamp_event_store.sv */
// Time-ordered event store: up to DEPTH (timestamp, value) pairs kept in ascending
// timestamp order in one simple dual-port RAM (one write, one registered read per
// cycle). Requests carry an op in s_axis_tuser: clear, add, find nearest, query.
// Every request returns exactly one response with status, nearest value, event count
// and duration (last timestamp, zero when empty). Clear and query go straight to the
// response, and so does an add into an empty or full store. An add walks down from
// the last entry moving every later-or-equal entry up one slot, then writes the new
// pair into the freed slot. Find nearest reads every held entry once; ties go to the
// earliest entry. One request is worked on at a time; the response sits in an output
// register, so the next request is taken while it waits.
module sorted_timestamp_event_store #(
    parameter int DEPTH       = stes_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = stes_pkg::VALUE_WIDTH_DEF,
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int OUT_W = stes_pkg::STATUS_W + stes_pkg::DATA_W + CW + stes_pkg::TIME_W,
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // time_in, value_in
    input  logic [stes_pkg::TIME_W+stes_pkg::DATA_W-1:0] s_axis_tdata,
    // func
    input  logic [stes_pkg::FUNC_W-1:0]                  s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // status, value_out, event_count, duration, zero pad
    output logic [OUT_TW-1:0]                            m_axis_tdata
);
    import stes_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int MW = TIME_W + SW;

    stes_req_t   req;
    stes_res_t   res;
    logic [CW-1:0] res_count;
    logic        res_valid;
    logic        res_ready;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [MW-1:0] rd_data;

    logic              out_valid_reg, out_valid_next;
    logic [OUT_TW-1:0] out_data_reg, out_data_next;

    assign req.func     = func_t'(s_axis_tuser);
    assign req.time_in  = s_axis_tdata[TIME_W-1:0];
    assign req.value_in = s_axis_tdata[TIME_W+DATA_W-1:TIME_W];

    stes_seq #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .res_count (res_count),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    stes_ram #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register frees the sequencer while a response waits
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_TW'({res.duration, res_count, res.value_out, res.status});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* test/sorted_timestamp_event_store_checker.sv */
`timescale 1ns / 1ps

module sorted_timestamp_event_store_checker #(
    parameter int DEPTH = stes_pkg::DEPTH_DEF
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  s_axis_tvalid,
    input  logic                                                  s_axis_tready,
    // time_in, value_in
    input  logic [stes_pkg::TIME_W+stes_pkg::DATA_W-1:0]          s_axis_tdata,
    // func
    input  logic [stes_pkg::FUNC_W-1:0]                           s_axis_tuser,
    input  logic                                                  m_axis_tvalid,
    input  logic                                                  m_axis_tready,
    // status, value_out, event_count, duration, zero pad
    input  logic [((stes_pkg::STATUS_W + stes_pkg::DATA_W + $clog2(DEPTH + 1)
                   + stes_pkg::TIME_W + 7) / 8) * 8 - 1:0]        m_axis_tdata,
    output int                                                    mismatches,
    output int                                                    outstanding
);
    import stes_pkg::*;

    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_LSB  = STATUS_W;
    localparam int CNT_LSB  = VAL_LSB + DATA_W;
    localparam int DUR_LSB  = CNT_LSB + CNT_W;
    localparam int OUT_W    = DUR_LSB + TIME_W;
    localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

    typedef struct packed {
        status_t             status;
        logic [DATA_W-1:0]   value;
        logic [CNT_W-1:0]    count;
        logic [TIME_W-1:0]   duration;
    } store_result_t;

    logic [TIME_W-1:0] held_times  [DEPTH];
    logic [DATA_W-1:0] held_values [DEPTH];
    int                held_count;
    store_result_t     expected_results [$];

    initial mismatches = 0;
    assign outstanding = expected_results.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // applies one request to the held copy of the store and returns its response
    task automatic store_apply(input func_t op, input logic [TIME_W-1:0] t,
                               input logic [DATA_W-1:0] v, output store_result_t res);
        int                pos;
        int                sel;
        logic [TIME_W-1:0] best;
        logic [TIME_W-1:0] gap;
        res.status = ST_OK;
        res.value  = '0;
        case (op)
            FUNC_CLEAR: begin
                held_count = 0;
            end
            FUNC_ADD: begin
                if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    pos = held_count;
                    // first held entry at or after the new time
                    for (int i = held_count - 1; i >= 0; i--)
                        if (held_times[i] >= t) pos = i;
                    for (int i = held_count; i > pos; i--) begin
                        held_times[i]  = held_times[i-1];
                        held_values[i] = held_values[i-1];
                    end
                    held_times[pos]  = t;
                    held_values[pos] = v;
                    held_count++;
                end
            end
            FUNC_NEAREST: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    best = '1;
                    sel  = 0;
                    for (int i = 0; i < held_count; i++) begin
                        gap = (t >= held_times[i]) ? t - held_times[i] : held_times[i] - t;
                        if (gap < best) begin
                            best = gap;
                            sel  = i;
                        end
                    end
                    res.value = held_values[sel];
                end
            end
            default: ;
        endcase
        res.count    = CNT_W'(held_count);
        res.duration = (held_count == 0) ? '0 : held_times[held_count-1];
    endtask

    always @(posedge aclk) begin
        store_result_t want;
        store_result_t fresh;
        if (!aresetn) begin
            held_count = 0;
            expected_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("response with no request waiting",
                                    64'(m_axis_tdata), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_axis_tdata[VAL_LSB-1:0] !== want.status)
                        report_mismatch("status", 64'(m_axis_tdata[VAL_LSB-1:0]),
                                        64'(want.status));
                    if (m_axis_tdata[CNT_LSB-1:VAL_LSB] !== want.value)
                        report_mismatch("value_out", 64'(m_axis_tdata[CNT_LSB-1:VAL_LSB]),
                                        64'(want.value));
                    if (m_axis_tdata[DUR_LSB-1:CNT_LSB] !== want.count)
                        report_mismatch("event_count", 64'(m_axis_tdata[DUR_LSB-1:CNT_LSB]),
                                        64'(want.count));
                    if (m_axis_tdata[OUT_W-1:DUR_LSB] !== want.duration)
                        report_mismatch("duration", 64'(m_axis_tdata[OUT_W-1:DUR_LSB]),
                                        64'(want.duration));
                    if (OUT_TW > OUT_W && m_axis_tdata[OUT_TW-1:OUT_W] !== '0)
                        report_mismatch("pad", 64'(m_axis_tdata[OUT_TW-1:OUT_W]), 64'd0);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                store_apply(func_t'(s_axis_tuser), s_axis_tdata[TIME_W-1:0],
                            s_axis_tdata[TIME_W+DATA_W-1:TIME_W], fresh);
                expected_results.push_back(fresh);
            end
        end
    end

endmodule

/* test/sorted_timestamp_event_store_tb.sv */
`timescale 1ns / 1ps

module sorted_timestamp_event_store_tb;
    import stes_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int OUT_W      = STATUS_W + DATA_W + CNT_W + TIME_W;
    localparam int OUT_TW     = ((OUT_W + 7) / 8) * 8;
    localparam int ITEMS      = 1450;
    localparam int IDLE_LIMIT = 4000;

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [TIME_W+DATA_W-1:0]   s_axis_tdata  = '0;
    logic [FUNC_W-1:0]          s_axis_tuser  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [OUT_TW-1:0]          m_axis_tdata;

    int  mismatches;
    int  outstanding;
    int  requests_sent = 0;
    bit  calm;

    // stretch of the run with no idling on either side
    assign calm = (requests_sent >= 500) && (requests_sent < 800);

    sorted_timestamp_event_store #(.DEPTH(DEPTH)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sorted_timestamp_event_store_checker #(.DEPTH(DEPTH)) event_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 13);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_request(input func_t op, input logic [TIME_W-1:0] t,
                                input logic [DATA_W-1:0] v);
        while (!calm && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {v, t};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        requests_sent++;
    endtask

    // mix of wide spread, tight clusters for duplicates and ties, and the extremes
    function automatic logic [TIME_W-1:0] pick_time();
        int mode;
        mode = $urandom_range(9);
        if (mode < 4) return $urandom;
        if (mode < 7) return $urandom_range(15);
        if (mode == 7) return 32'hFFFF_FFF0 + $urandom_range(15);
        if (mode == 8) return '0;
        return '1;
    endfunction

    initial begin
        int kind;
        int sel;
        int n;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(FUNC_QUERY,   32'd0, 32'd0);
        send_request(FUNC_NEAREST, 32'd0, 32'd0);
        send_request(FUNC_ADD,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // distance equals the largest value, so the first entry must still win
        send_request(FUNC_NEAREST, 32'd0, 32'd0);
        send_request(FUNC_ADD,     32'd0, 32'd0);
        send_request(FUNC_ADD,     32'd100, 32'hA5A5_A5A5);
        // equal time goes in front of the held one
        send_request(FUNC_ADD,     32'd100, 32'h5A5A_5A5A);
        send_request(FUNC_NEAREST, 32'd100, 32'd0);
        send_request(FUNC_ADD,     32'd200, 32'd1);
        // equidistant target, earliest entry wins
        send_request(FUNC_NEAREST, 32'd150, 32'd0);
        send_request(FUNC_NEAREST, 32'hFFFF_FFFF, 32'd0);
        send_request(FUNC_NEAREST, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(FUNC_QUERY,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_QUERY,   32'd0, 32'd0);
        send_request(FUNC_ADD,     32'd7, 32'd3);
        send_request(FUNC_NEAREST, 32'hFFFF_FFFF, 32'd0);
        send_request(FUNC_CLEAR,   32'd0, 32'd0);
        send_request(FUNC_NEAREST, 32'd7, 32'd0);

        while (requests_sent < ITEMS) begin
            kind = $urandom_range(9);
            if (kind < 7) begin
                if ($urandom_range(4) != 0) send_request(FUNC_CLEAR, $urandom, $urandom);
                sel = $urandom_range(9);
                if (sel < 5)      n = $urandom_range(12, 1);
                else if (sel < 8) n = $urandom_range(63, 13);
                else              n = $urandom_range(70, 60);
                repeat (n) begin
                    send_request(FUNC_ADD, pick_time(), $urandom);
                    if ($urandom_range(9) < 3)
                        send_request($urandom_range(1) ? FUNC_NEAREST : FUNC_QUERY,
                                     pick_time(), $urandom);
                end
                repeat ($urandom_range(4, 1)) send_request(FUNC_NEAREST, pick_time(), $urandom);
            end else begin
                repeat ($urandom_range(8, 1))
                    send_request(func_t'($urandom_range(3)), pick_time(), $urandom);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (outstanding != 0) @(posedge aclk);
        repeat (2 * DEPTH + 10) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sorted_timestamp_event_store.f */
rtl/core/stes_pkg.sv
rtl/core/stes_ram.sv
rtl/core/stes_seq.sv
rtl/core/sorted_timestamp_event_store.sv
test/sorted_timestamp_event_store_checker.sv
test/sorted_timestamp_event_store_tb.sv
